### src/bitmap_page_frame_allocator_defines.svh
// Assertion macros shared by the checker of the bitmap page frame allocator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bpfa_pkg.sv
// Package of the bitmap page frame allocator: item types and action codes.
// Used by the top level and by its checker; depends on nothing.
package bpfa_pkg;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic CFG_PAGE_LIMIT = 1'b0;
    localparam logic CFG_ALLOC_BASE = 1'b1;

    localparam logic [12:0] PAGE_LIMIT_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] page_index;
    } bpfa_in_t;

    typedef struct packed {
        logic        status;
        logic [31:0] frame_address;
        logic [11:0] frame_number;
        logic        frame_used;
    } bpfa_out_t;

endpackage

### src/bitmap_page_frame_allocator.sv
// For mark-used and query the item passes from S_IDLE through S_RMW to S_FINISH, and the result
// is registered from there; allocate stays in S_SCAN while the next-fit scan steps to further bitmap bytes.
// A new item is accepted only in S_IDLE, so none is taken until the last has passed its result step;
// a stalled result holds the next item in S_FINISH until it is taken.
// After reset a clearing pass zeroes the bitmap, one byte per cycle, over all (NUM_PAGES+7)/8 bytes,
// while no item is accepted; configuration writes are taken at all times.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  bpfa_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output bpfa_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BYTES = (NUM_PAGES + 7) / 8;
    localparam int BW    = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int NW    = $clog2(NUM_PAGES) + 1;
    localparam int FW    = (NW > 13) ? NW : 13;
    localparam logic [FW-1:0] NUM_PAGES_F = FW'(NUM_PAGES);
    localparam logic [BW-1:0] LAST_BYTE   = BW'(BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_FINISH
    } state_t;

    logic [7:0]    bitmap_mem [BYTES];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [BW-1:0] mem_waddr;
    logic [BW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    state_t        state_reg, state_next;
    logic [BW-1:0] clr_addr_reg, clr_addr_next;
    logic [BW-1:0] cursor_reg, cursor_next;
    logic [12:0]   page_limit_reg, page_limit_next;
    logic [31:0]   alloc_base_reg, alloc_base_next;
    logic [1:0]    action_reg, action_next;
    logic [11:0]   idx_reg, idx_next;
    logic [FW-1:0] base_reg, base_next;
    logic [FW-1:0] lim_reg, lim_next;
    logic          res_ok_reg, res_ok_next;
    logic          res_fail_reg, res_fail_next;
    logic          res_used_reg, res_used_next;
    logic [FW-1:0] res_frame_reg, res_frame_next;
    logic          out_valid_reg, out_valid_next;
    bpfa_out_t     out_data_reg, out_data_next;

    logic [FW-1:0] lim_eff;
    logic [FW-1:0] in_idx_f;
    logic          in_idx_ok;
    logic [FW-1:0] idx_f;
    logic          idx_ok;
    logic [FW-1:0] diff;
    logic [7:0]    byte_mask;
    logic [7:0]    free_bits;
    logic [2:0]    free_pos;
    logic [FW-1:0] next_base;
    logic [31:0]   addr_off;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bitmap_mem[mem_raddr];
        end
    end

    always_comb
    begin
        lim_eff   = (FW'(page_limit_reg) > NUM_PAGES_F) ? NUM_PAGES_F : FW'(page_limit_reg);
        in_idx_f  = FW'(in_data.page_index);
        in_idx_ok = in_idx_f < NUM_PAGES_F;
        idx_f     = FW'(idx_reg);
        idx_ok    = idx_f < NUM_PAGES_F;
        diff      = lim_reg - base_reg;
        byte_mask = (diff >= FW'(8)) ? 8'hFF : ((8'd1 << diff[2:0]) - 8'd1);
        free_bits = ~rd_data_reg & byte_mask;
        free_pos  = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                free_pos = 3'(i);
            end
        end
        next_base = base_reg + FW'(8);
        addr_off  = 32'(64'(res_frame_reg) << PAGE_SHIFT);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cursor_next     = cursor_reg;
        page_limit_next = page_limit_reg;
        alloc_base_next = alloc_base_reg;
        action_next     = action_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        lim_next        = lim_reg;
        res_ok_next     = res_ok_reg;
        res_fail_next   = res_fail_reg;
        res_used_next   = res_used_reg;
        res_frame_next  = res_frame_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_LIMIT: page_limit_next = cfg_data[12:0];
                CFG_ALLOC_BASE: alloc_base_next = cfg_data;
                default:        alloc_base_next = alloc_base_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + BW'(1);
                if (clr_addr_reg == LAST_BYTE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next   = in_data.action;
                    idx_next      = in_data.page_index;
                    res_ok_next   = 1'b0;
                    res_fail_next = 1'b0;
                    res_used_next = 1'b0;
                    if (in_data.action == ACT_ALLOC)
                    begin
                        base_next  = FW'(cursor_reg) << 3;
                        lim_next   = lim_eff;
                        mem_re     = 1'b1;
                        mem_raddr  = cursor_reg;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        mem_re     = in_idx_ok;
                        mem_raddr  = in_idx_f[3 +: BW];
                        state_next = S_RMW;
                    end
                end
            end
            S_SCAN:
            begin
                if (base_reg >= lim_reg)
                begin
                    res_fail_next = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (free_bits != 8'd0)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = base_reg[3 +: BW];
                    mem_wdata      = rd_data_reg | (8'd1 << free_pos);
                    cursor_next    = base_reg[3 +: BW];
                    res_frame_next = base_reg | FW'(free_pos);
                    res_ok_next    = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    base_next = next_base;
                    if (next_base < NUM_PAGES_F)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = next_base[3 +: BW];
                    end
                end
            end
            S_RMW:
            begin
                if (idx_ok && action_reg == ACT_MARK)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = idx_f[3 +: BW];
                    mem_wdata   = rd_data_reg | (8'd1 << idx_reg[2:0]);
                    cursor_next = idx_f[3 +: BW];
                end
                if (idx_ok && action_reg == ACT_QUERY)
                begin
                    res_used_next = rd_data_reg[idx_reg[2:0]];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = res_fail_reg ? STATUS_FULL : STATUS_OK;
                    out_data_next.frame_address = res_ok_reg ? (alloc_base_reg + addr_off)
                                                             : 32'd0;
                    out_data_next.frame_number  = res_ok_reg ? res_frame_reg[11:0] : 12'd0;
                    out_data_next.frame_used    = res_used_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cursor_reg     <= '0;
            page_limit_reg <= PAGE_LIMIT_RESET;
            alloc_base_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cursor_reg     <= cursor_next;
            page_limit_reg <= page_limit_next;
            alloc_base_reg <= alloc_base_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        idx_reg       <= idx_next;
        base_reg      <= base_next;
        lim_reg       <= lim_next;
        res_ok_reg    <= res_ok_next;
        res_fail_reg  <= res_fail_next;
        res_used_reg  <= res_used_next;
        res_frame_reg <= res_frame_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/bpfa_checker.sv
// Port-level checker for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and on the assertion macros in the defines header.
`include "bitmap_page_frame_allocator_defines.svh"

module bpfa_checker
    import bpfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input bpfa_in_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input bpfa_out_t out_data
);

    // The block works on one item at a time, so it never takes two items in a row.
    `BPFA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "item accepted back to back")

    // A failed allocation carries no frame and no query answer.
    `BPFA_ASSERT_NOW(a_fail_zero, out_valid && out_data.status == STATUS_FULL, out_data.frame_address == 32'd0 && out_data.frame_number == 12'd0 && !out_data.frame_used, "failed item has nonzero fields")

    `BPFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    `BPFA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
